@@ rtl/npcs_pkg.sv @@
// npcs_pkg: shared types, constants and the channel ranking function of the
// nearest palette color search unit.
// no dependencies; compiled first
package npcs_pkg;

  localparam int COLOR_W = 16;
  localparam int IDX_W   = 8;
  localparam int DIST_W  = 18;
  localparam int RANK_W  = 6;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_kind_t;

  typedef struct packed {
    logic               avail;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } palette_entry_t;

  localparam int ENTRY_W = $bits(palette_entry_t);

  // controller to datapath
  typedef struct packed {
    logic clear_write;
    logic load_write;
    logic start_lookup;
    logic scan_read;
    logic load_result;
  } npcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic addr_last;
    logic pipe_busy;
    logic out_free;
  } npcs_sts_t;

  // position (1..3) of red, green and blue, packed {pr, pg, pb}
  function automatic logic [RANK_W-1:0] rank_code(input logic [COLOR_W-1:0] r,
                                                  input logic [COLOR_W-1:0] g,
                                                  input logic [COLOR_W-1:0] b);
    logic [1:0] pr, pg, pb;
    if (r > g) begin
      if (r > b) begin
        pr = 2'd1;
        if (g > b) begin
          pg = 2'd2;
          pb = 2'd3;
        end else begin
          pb = 2'd2;
          pg = 2'd3;
        end
      end else begin
        pb = 2'd1;
        pr = 2'd2;
        pg = 2'd3;
      end
    end else begin
      if (g > b) begin
        pg = 2'd1;
        if (r > b) begin
          pr = 2'd2;
          pb = 2'd3;
        end else begin
          pb = 2'd2;
          pr = 2'd3;
        end
      end else begin
        pb = 2'd1;
        pg = 2'd2;
        pr = 2'd3;
      end
    end
    return {pr, pg, pb};
  endfunction

endpackage

@@ rtl/npcs_req_if.sv @@
// npcs_req_if: request channel (palette load or color lookup)
// depends on npcs_pkg
interface npcs_req_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [IDX_W-1:0]   entry_index;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               available;

  modport source (output valid, req_type, entry_index, red, green, blue, available,
                  input ready);
  modport sink (input valid, req_type, entry_index, red, green, blue, available,
                output ready);
endinterface

@@ rtl/npcs_rsp_if.sv @@
// npcs_rsp_if: result channel of a color lookup
// depends on npcs_pkg
interface npcs_rsp_if import npcs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   best_index;
  logic [COLOR_W-1:0] best_red;
  logic [COLOR_W-1:0] best_green;
  logic [COLOR_W-1:0] best_blue;
  logic [DIST_W-1:0]  best_distance;
  logic               order_matched;
  logic               no_match;

  modport source (output valid, best_index, best_red, best_green, best_blue,
                  best_distance, order_matched, no_match, input ready);
  modport sink (input valid, best_index, best_red, best_green, best_blue,
                best_distance, order_matched, no_match, output ready);
endinterface

@@ rtl/npcs_ram.sv @@
// npcs_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
module npcs_ram #(
  parameter int WIDTH = 49,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/npcs_ctrl.sv @@
// npcs_ctrl: sequencer for the clearing pass, palette loads and lookup scans
// depends on npcs_pkg
module npcs_ctrl import npcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_type,
  output logic      req_ready,
  input  npcs_sts_t sts,
  output npcs_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd              = '0;
    cmd.clear_write  = (state == ST_CLEAR);
    cmd.load_write   = accept && (req_type == REQ_LOAD);
    cmd.start_lookup = accept && (req_type == REQ_LOOKUP);
    cmd.scan_read    = (state == ST_SCAN);
    cmd.load_result  = (state == ST_RESULT) && sts.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.addr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.start_lookup) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.addr_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/npcs_datapath.sv @@
// npcs_datapath: palette memory, distance pipeline, running minima and result register
// depends on npcs_pkg and npcs_ram
module npcs_datapath import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COARSE_SHIFT    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  npcs_cmd_t          cmd,
  output npcs_sts_t          sts,
  input  logic [IDX_W-1:0]   entry_index,
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  input  logic               available,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [IDX_W-1:0]   best_index,
  output logic [COLOR_W-1:0] best_red,
  output logic [COLOR_W-1:0] best_green,
  output logic [COLOR_W-1:0] best_blue,
  output logic [DIST_W-1:0]  best_distance,
  output logic               order_matched,
  output logic               no_match
);

  localparam int AW  = $clog2(PALETTE_ENTRIES);
  localparam int IXW = (AW > IDX_W) ? AW : IDX_W;
  localparam int LXW = IXW + 1;
  localparam int MW  = COLOR_W + 1 - COARSE_SHIFT;   // coarse magnitude
  localparam int SQW = 2 * MW;
  localparam int DW  = SQW + 2;
  localparam int DXW = (DW > DIST_W) ? DW : DIST_W;

  // |floor((t - e) / 2^shift)|
  function automatic logic [MW-1:0] coarse_mag(input logic [COLOR_W-1:0] t,
                                               input logic [COLOR_W-1:0] e);
    logic signed [COLOR_W:0] d;
    logic signed [COLOR_W:0] s;
    logic        [COLOR_W:0] a;
    d = $signed({1'b0, t}) - $signed({1'b0, e});
    s = d >>> COARSE_SHIFT;
    a = s[COLOR_W] ? unsigned'(-s) : unsigned'(s);
    return a[MW-1:0];
  endfunction

  // address counter shared by the clearing pass and the scan
  logic [AW-1:0] addr;
  logic          addr_last;

  assign addr_last = (addr == AW'(PALETTE_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else if (cmd.clear_write || cmd.scan_read) begin
      addr <= addr_last ? '0 : addr + 1'b1;
    end
  end

  // palette memory write side
  logic [LXW-1:0] entry_ext;
  logic           load_in_range;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  palette_entry_t ram_wdata;
  palette_entry_t ram_rdata;

  assign entry_ext     = LXW'(entry_index);
  assign load_in_range = entry_ext < LXW'(PALETTE_ENTRIES);
  assign ram_we        = cmd.clear_write || (cmd.load_write && load_in_range);
  assign ram_waddr     = cmd.clear_write ? addr : entry_ext[AW-1:0];

  always_comb begin
    if (cmd.clear_write) begin
      ram_wdata = '0;
    end else begin
      ram_wdata.avail = available;
      ram_wdata.red   = red;
      ram_wdata.green = green;
      ram_wdata.blue  = blue;
    end
  end

  npcs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_read),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // lookup target
  logic [COLOR_W-1:0] tgt_red, tgt_green, tgt_blue;
  logic [RANK_W-1:0]  tgt_rank;

  always_ff @(posedge clk) begin
    if (cmd.start_lookup) begin
      tgt_red   <= red;
      tgt_green <= green;
      tgt_blue  <= blue;
      tgt_rank  <= rank_code(red, green, blue);
    end
  end

  // stage 1: memory read data
  logic          v1;
  logic [AW-1:0] idx1;
  // stage 2: coarse magnitudes and rank match
  logic           v2, match2;
  logic [AW-1:0]  idx2;
  palette_entry_t col2;
  logic [MW-1:0]  mag2_r, mag2_g, mag2_b;
  // stage 3: squares
  logic           v3, match3;
  logic [AW-1:0]  idx3;
  palette_entry_t col3;
  logic [SQW-1:0] sq3_r, sq3_g, sq3_b;
  // stage 4: distance
  logic           v4, match4;
  logic [AW-1:0]  idx4;
  palette_entry_t col4;
  logic [DW-1:0]  dist4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= cmd.scan_read;
      v2 <= v1 && ram_rdata.avail;   // unavailable entries drop out here
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= addr;
    idx2   <= idx1;
    col2   <= ram_rdata;
    match2 <= rank_code(ram_rdata.red, ram_rdata.green, ram_rdata.blue) == tgt_rank;
    mag2_r <= coarse_mag(tgt_red, ram_rdata.red);
    mag2_g <= coarse_mag(tgt_green, ram_rdata.green);
    mag2_b <= coarse_mag(tgt_blue, ram_rdata.blue);
    idx3   <= idx2;
    col3   <= col2;
    match3 <= match2;
    sq3_r  <= SQW'(mag2_r) * SQW'(mag2_r);
    sq3_g  <= SQW'(mag2_g) * SQW'(mag2_g);
    sq3_b  <= SQW'(mag2_b) * SQW'(mag2_b);
    idx4   <= idx3;
    col4   <= col3;
    match4 <= match3;
    dist4  <= DW'(sq3_r) + DW'(sq3_g) + DW'(sq3_b);
  end

  // running minima, strict less keeps the lowest index on ties
  logic           f_found, m_found;
  logic [DW-1:0]  f_dist, m_dist;
  logic [AW-1:0]  f_idx, m_idx;
  palette_entry_t f_col, m_col;

  always_ff @(posedge clk) begin
    if (rst || cmd.start_lookup) begin
      f_found <= 1'b0;
      m_found <= 1'b0;
    end else if (v4) begin
      if (!f_found || dist4 < f_dist) begin
        f_found <= 1'b1;
        f_dist  <= dist4;
        f_idx   <= idx4;
        f_col   <= col4;
      end
      if (match4 && (!m_found || dist4 < m_dist)) begin
        m_found <= 1'b1;
        m_dist  <= dist4;
        m_idx   <= idx4;
        m_col   <= col4;
      end
    end
  end

  // result selection
  logic           sel_matched;
  logic [DW-1:0]  sel_dist;
  logic [DXW-1:0] sel_dist_ext;
  logic [IXW-1:0] sel_idx_ext;
  palette_entry_t sel_col;

  assign sel_matched  = m_found;
  assign sel_dist     = m_found ? m_dist : f_dist;
  assign sel_dist_ext = DXW'(sel_dist);
  assign sel_idx_ext  = IXW'(m_found ? m_idx : f_idx);
  assign sel_col      = m_found ? m_col : f_col;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_result) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      if (!f_found) begin
        best_index    <= '0;
        best_red      <= '0;
        best_green    <= '0;
        best_blue     <= '0;
        best_distance <= '0;
        order_matched <= 1'b0;
        no_match      <= 1'b1;
      end else begin
        best_index    <= sel_idx_ext[IDX_W-1:0];
        best_red      <= sel_col.red;
        best_green    <= sel_col.green;
        best_blue     <= sel_col.blue;
        best_distance <= (sel_dist_ext > DXW'(DIST_MAX)) ? DIST_MAX
                                                          : sel_dist_ext[DIST_W-1:0];
        order_matched <= sel_matched;
        no_match      <= 1'b0;
      end
    end
  end

  assign sts.addr_last = addr_last;
  assign sts.pipe_busy = v1 || v2 || v3 || v4;
  assign sts.out_free  = !rsp_valid || rsp_ready;

endmodule

@@ rtl/nearest_palette_color_search_unit.sv @@
// nearest_palette_color_search_unit: top level, controller plus datapath
// depends on npcs_pkg, npcs_req_if, npcs_rsp_if, npcs_ctrl, npcs_datapath
//
// Keeps a palette of PALETTE_ENTRIES colors, each with an availability mark,
// and answers lookups with the nearest available entry, preferring entries
// whose channel ranking matches the target's. After reset the block clears
// the palette memory and takes no request until that pass is done. A load
// gives no result; indexes at or above PALETTE_ENTRIES are dropped. A lookup
// reads the palette memory one entry per cycle through its single read port,
// then waits for the distance pipeline to drain (sooner when the last palette
// slots are unavailable) and for any earlier result still waiting on the
// output channel before the result register is loaded.
// One request is worked on at a time.
module nearest_palette_color_search_unit import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COARSE_SHIFT    = 8
) (
  input logic      clk,
  input logic      rst,
  npcs_req_if.sink   req,
  npcs_rsp_if.source rsp
);

  npcs_cmd_t cmd;
  npcs_sts_t sts;

  npcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  npcs_datapath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .COARSE_SHIFT    (COARSE_SHIFT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .entry_index   (req.entry_index),
    .red           (req.red),
    .green         (req.green),
    .blue          (req.blue),
    .available     (req.available),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .best_index    (rsp.best_index),
    .best_red      (rsp.best_red),
    .best_green    (rsp.best_green),
    .best_blue     (rsp.best_blue),
    .best_distance (rsp.best_distance),
    .order_matched (rsp.order_matched),
    .no_match      (rsp.no_match)
  );

  // no new transaction while the palette is being scanned
  assert property (@(posedge clk) disable iff (rst) cmd.scan_read |-> !req.ready)
    else $error("request accepted during scan");

  // a result is never written over one that is still waiting
  assert property (@(posedge clk) disable iff (rst) cmd.load_result |-> sts.out_free)
    else $error("result register overwritten");

  assert property (@(posedge clk) disable iff (rst) cmd.load_result |=> rsp.valid)
    else $error("result not presented after load");

  // clearing pass and palette loads share the write port
  assert property (@(posedge clk) disable iff (rst) !(cmd.clear_write && cmd.load_write))
    else $error("write port conflict");

endmodule

@@ bench/npcs_result_checker.sv @@
`timescale 1ns / 100ps
// npcs_result_checker: watches the request and result channels, keeps its own copy of the
// palette, predicts every lookup result and compares it field by field
// depends on npcs_pkg, npcs_req_if, npcs_rsp_if
module npcs_result_checker import npcs_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COARSE_SHIFT    = 8
) (
  input  logic clk,
  input  logic rst,
  npcs_req_if  req,
  npcs_rsp_if  rsp,
  output int   errors,
  output int   pending,
  output int   loads_seen,
  output int   lookups_seen,
  output int   matched_seen,
  output int   fallback_seen,
  output int   empty_seen
);

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [DIST_W-1:0]  distance;
    logic               matched;
    logic               empty;
  } lookup_result_t;

  palette_entry_t palette_copy [PALETTE_ENTRIES];
  lookup_result_t expected_results [$];

  // positions {red, green, blue}, ties resolved as the strict-greater tree does
  function automatic logic [5:0] channel_ranking(input logic [COLOR_W-1:0] r,
                                                 input logic [COLOR_W-1:0] g,
                                                 input logic [COLOR_W-1:0] b);
    logic [2:0] gt;
    logic [5:0] pos;
    gt = {r > g, r > b, g > b};
    casez (gt)
      3'b111:  pos = {2'd1, 2'd2, 2'd3};
      3'b110:  pos = {2'd1, 2'd3, 2'd2};
      3'b10?:  pos = {2'd2, 2'd3, 2'd1};
      3'b011:  pos = {2'd2, 2'd1, 2'd3};
      3'b001:  pos = {2'd3, 2'd1, 2'd2};
      default: pos = {2'd3, 2'd2, 2'd1};
    endcase
    return pos;
  endfunction

  // floor shift of the signed difference, then squared
  function automatic longint unsigned coarse_cost(input logic [COLOR_W-1:0] t,
                                                  input logic [COLOR_W-1:0] e);
    logic signed [COLOR_W:0] diff;
    logic signed [COLOR_W:0] step;
    diff = $signed({1'b0, t}) - $signed({1'b0, e});
    step = diff >>> COARSE_SHIFT;
    return longint'(step) * longint'(step);
  endfunction

  function automatic lookup_result_t nearest_color(input logic [COLOR_W-1:0] r,
                                                   input logic [COLOR_W-1:0] g,
                                                   input logic [COLOR_W-1:0] b);
    lookup_result_t    res;
    logic [5:0]        target_rank;
    longint unsigned   d, best_any, best_same, sel_d;
    int                any_i, same_i, sel;
    bit                any_found, same_found;
    palette_entry_t    e;
    res = '0;
    target_rank = channel_ranking(r, g, b);
    any_found = 0;
    same_found = 0;
    best_any = 0;
    best_same = 0;
    any_i = 0;
    same_i = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      e = palette_copy[i];
      if (e.avail) begin
        d = coarse_cost(r, e.red) + coarse_cost(g, e.green) + coarse_cost(b, e.blue);
        if (!any_found || d < best_any) begin
          any_found = 1;
          best_any = d;
          any_i = i;
        end
        if (channel_ranking(e.red, e.green, e.blue) == target_rank &&
            (!same_found || d < best_same)) begin
          same_found = 1;
          best_same = d;
          same_i = i;
        end
      end
    end
    if (!any_found) begin
      res.empty = 1'b1;
      return res;
    end
    sel = same_found ? same_i : any_i;
    sel_d = same_found ? best_same : best_any;
    e = palette_copy[sel];
    res.index = IDX_W'(sel);
    res.red = e.red;
    res.green = e.green;
    res.blue = e.blue;
    res.distance = (sel_d > DIST_MAX) ? DIST_MAX : DIST_W'(sel_d);
    res.matched = same_found;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin : watch
    lookup_result_t want;
    if (rst) begin
      foreach (palette_copy[i]) palette_copy[i] = '0;
      expected_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no lookup outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("best_index", rsp.best_index, want.index);
          check_field("best_red", rsp.best_red, want.red);
          check_field("best_green", rsp.best_green, want.green);
          check_field("best_blue", rsp.best_blue, want.blue);
          check_field("best_distance", rsp.best_distance, want.distance);
          check_field("order_matched", rsp.order_matched, want.matched);
          check_field("no_match", rsp.no_match, want.empty);
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LOAD) begin
          loads_seen++;
          if (req.entry_index < PALETTE_ENTRIES)
            palette_copy[req.entry_index] = {req.available, req.red, req.green, req.blue};
        end else begin
          want = nearest_color(req.red, req.green, req.blue);
          expected_results.push_back(want);
          lookups_seen++;
          if (want.empty) empty_seen++;
          else if (want.matched) matched_seen++;
          else fallback_seen++;
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

@@ bench/tb_nearest_palette_color_search_unit.sv @@
`timescale 1ns / 100ps
// tb_nearest_palette_color_search_unit: drives palette loads and color lookups into the
// search unit with random idling on both channels and gives the verdict
// depends on npcs_pkg, npcs_req_if, npcs_rsp_if, npcs_result_checker and the rtl
module tb_nearest_palette_color_search_unit;
  import npcs_pkg::*;

  localparam int PALETTE_ENTRIES = 256;
  localparam int COARSE_SHIFT    = 8;
  localparam int RANDOM_ITEMS    = 725;
  // covers a full lookup scan, the clearing pass and long random stalls
  localparam int STALL_LIMIT     = 5000;

  logic clk;
  logic rst;
  int   tx_gap_pct   = 28;
  int   rx_stall_pct = 77;
  int   idle_cycles  = 0;
  int   errors, pending, loads_seen, lookups_seen, matched_seen, fallback_seen, empty_seen;

  palette_entry_t recent_colors [8];
  int             recent_next = 0;

  npcs_req_if req_ch ();
  npcs_rsp_if rsp_ch ();

  nearest_palette_color_search_unit #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COARSE_SHIFT   (COARSE_SHIFT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  npcs_result_checker #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COARSE_SHIFT   (COARSE_SHIFT)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .errors       (errors),
    .pending      (pending),
    .loads_seen   (loads_seen),
    .lookups_seen (lookups_seen),
    .matched_seen (matched_seen),
    .fallback_seen(fallback_seen),
    .empty_seen   (empty_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_req(input req_kind_t kind, input logic [IDX_W-1:0] idx,
                          input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                          input logic [COLOR_W-1:0] b, input logic av);
    while ($urandom_range(99) < tx_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.entry_index <= idx;
    req_ch.red         <= r;
    req_ch.green       <= g;
    req_ch.blue        <= b;
    req_ch.available   <= av;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic lookup(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                        input logic [COLOR_W-1:0] b);
    // index and availability are don't-care on a lookup, so keep them toggling
    send_req(REQ_LOOKUP, IDX_W'($urandom), r, g, b, 1'($urandom));
  endtask

  // sender holds off until the result of every accepted lookup has come back
  task automatic wait_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [COLOR_W-1:0] rand_chan();
    case ($urandom_range(4))
      0: return COLOR_W'($urandom_range(65535));
      1: begin
        case ($urandom_range(8))
          0: return 16'h0000;
          1: return 16'h0001;
          2: return 16'h00ff;
          3: return 16'h0100;
          4: return 16'h7fff;
          5: return 16'h8000;
          6: return 16'hff00;
          7: return 16'hfffe;
          default: return 16'hffff;
        endcase
      end
      2: return {8'($urandom_range(255)), 8'h00};
      3: return COLOR_W'($urandom_range(3) * 256 + $urandom_range(255));
      default: return COLOR_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic rand_color(output logic [COLOR_W-1:0] r, output logic [COLOR_W-1:0] g,
                            output logic [COLOR_W-1:0] b);
    r = rand_chan();
    g = rand_chan();
    b = rand_chan();
    // equal channels exercise the tie order of the ranking
    case ($urandom_range(9))
      0: g = r;
      1: b = g;
      2: r = b;
      3: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int                 roll;
    logic [COLOR_W-1:0] r, g, b;
    logic [IDX_W-1:0]   idx;
    logic               av;
    palette_entry_t     pick;

    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.req_type    <= REQ_LOAD;
    req_ch.entry_index <= '0;
    req_ch.red         <= '0;
    req_ch.green       <= '0;
    req_ch.blue        <= '0;
    req_ch.available   <= 1'b0;
    foreach (recent_colors[i]) recent_colors[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty palette right after reset
    lookup(16'h1234, 16'h5678, 16'h9abc);
    wait_results();
    // an unavailable entry must not be chosen
    send_req(REQ_LOAD, 8'd0, 16'hffff, 16'h0000, 16'h0000, 1'b0);
    lookup(16'h0000, 16'h0000, 16'h0000);
    // largest possible distance, all channels tied
    send_req(REQ_LOAD, 8'd255, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    lookup(16'h0000, 16'h0000, 16'h0000);
    // no entry with the target ranking: fallback to nearest, then a ranking match
    send_req(REQ_LOAD, 8'd5, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    lookup(16'h0001, 16'h0000, 16'h0000);
    send_req(REQ_LOAD, 8'd10, 16'h8000, 16'h0100, 16'h0000, 1'b1);
    lookup(16'hffff, 16'h8000, 16'h0001);
    // entry just above target: shift rounds toward minus infinity
    send_req(REQ_LOAD, 8'd20, 16'h0001, 16'h0101, 16'h0201, 1'b1);
    lookup(16'h0000, 16'h0100, 16'h0200);
    // equal distances: lowest slot wins
    send_req(REQ_LOAD, 8'd40, 16'h4000, 16'h2000, 16'h1000, 1'b1);
    send_req(REQ_LOAD, 8'd30, 16'h4000, 16'h2000, 16'h1000, 1'b1);
    lookup(16'h4000, 16'h2000, 16'h1000);
    // the remaining rankings and a red/green tie
    lookup(16'h1000, 16'h3000, 16'h0100);
    lookup(16'h0100, 16'h3000, 16'h1000);
    lookup(16'h2000, 16'h0100, 16'h3000);
    lookup(16'h3000, 16'h0100, 16'h2000);
    lookup(16'h5000, 16'h5000, 16'h1000);
    send_req(REQ_LOAD, 8'd255, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    lookup(16'hffff, 16'hffff, 16'hffff);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_results();
        tx_gap_pct   = 77;
        rx_stall_pct = 28;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_results();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 55) begin
        // low slots get rewritten often, so duplicates and overwrites happen
        idx = ($urandom_range(2) == 0) ? IDX_W'($urandom_range(15)) : IDX_W'($urandom_range(255));
        av  = ($urandom_range(9) != 0);
        if ($urandom_range(3) == 0) begin
          pick = recent_colors[$urandom_range(7)];
          r = pick.red;
          g = pick.green;
          b = pick.blue;
        end else begin
          rand_color(r, g, b);
        end
        recent_colors[recent_next] = {av, r, g, b};
        recent_next = (recent_next + 1) % 8;
        send_req(REQ_LOAD, idx, r, g, b, av);
      end else begin
        if ($urandom_range(9) < 4) begin
          pick = recent_colors[$urandom_range(7)];
          r = pick.red;
          g = pick.green;
          b = pick.blue;
          if ($urandom_range(1) == 0) begin
            r = r ^ COLOR_W'($urandom_range(3));
            b = b ^ COLOR_W'($urandom_range(3));
          end
        end else begin
          rand_color(r, g, b);
        end
        lookup(r, g, b);
      end
    end

    wait_results();
    repeat (PALETTE_ENTRIES + 16) @(posedge clk);

    $display("covered %0d palette loads and %0d lookups under three idling mixes",
             loads_seen, lookups_seen);
    $display("lookup outcomes: %0d same ranking, %0d fallback, %0d empty palette",
             matched_seen, fallback_seen, empty_seen);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
